FILE: sv/boundary_fill_8_connected_core_defines.svh
// Assertion macros shared by the boundary fill core.
`ifndef BOUNDARY_FILL_8_CONNECTED_CORE_DEFINES_SVH
`define BOUNDARY_FILL_8_CONNECTED_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BF8C_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BF8C_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bf8c_pkg.sv
// Package of types, constants and helper functions for the boundary fill core.
package bf8c_pkg;

  // Default geometry and colour depth
  localparam int GRID_ROWS_DEF  = 16;
  localparam int GRID_COLS_DEF  = 16;
  localparam int COLOR_BITS_DEF = 8;

  // Field widths of the stream words
  localparam int FUNC_W  = 2;
  localparam int COORD_W = 6;
  localparam int COLOR_W = 8;
  localparam int COUNT_W = 13;
  localparam int TDATA_W = 24;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [COLOR_W-1:0] FILL_RESET  = 8'd1;
  localparam logic [COLOR_W-1:0] BOUND_RESET = 8'd7;
  localparam logic REG_FILL     = 1'b0;
  localparam logic REG_BOUNDARY = 1'b1;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FILL  = 2'd2;

  // Neighbour offset codes along one axis
  localparam logic [1:0] OFF_ZERO  = 2'd0;
  localparam logic [1:0] OFF_MINUS = 2'd1;
  localparam logic [1:0] OFF_PLUS  = 2'd2;

  localparam logic [3:0] NBR_COUNT = 4'd8;

  // Neighbour address and whether it lies on the grid
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               on_grid;
  } visit_rsp_t;

  // Row offset of neighbour k, scanning the eight around the centre
  function automatic logic [1:0] nbr_dr(input logic [2:0] k);
    logic [1:0] d;
    unique case (k)
      3'd0, 3'd1, 3'd2: d = OFF_MINUS;
      3'd3, 3'd4:       d = OFF_ZERO;
      default:          d = OFF_PLUS;
    endcase
    return d;
  endfunction

  // Column offset of neighbour k
  function automatic logic [1:0] nbr_dc(input logic [2:0] k);
    logic [1:0] d;
    unique case (k)
      3'd0, 3'd3, 3'd5: d = OFF_MINUS;
      3'd1, 3'd6:       d = OFF_ZERO;
      default:          d = OFF_PLUS;
    endcase
    return d;
  endfunction

endpackage

FILE: sv/bf8c_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module bf8c_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bf8c_visit.sv
// Shared visit unit: neighbour address generation and fill colour test.
module bf8c_visit #(
  parameter int GRID_ROWS  = bf8c_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS  = bf8c_pkg::GRID_COLS_DEF,
  parameter int COLOR_BITS = bf8c_pkg::COLOR_BITS_DEF
) (
  input  logic [bf8c_pkg::COORD_W-1:0] center_row_i,
  input  logic [bf8c_pkg::COORD_W-1:0] center_col_i,
  input  logic [2:0]                   nbr_idx_i,
  input  logic [COLOR_BITS-1:0]        pix_i,
  input  logic [COLOR_BITS-1:0]        fill_i,
  input  logic [COLOR_BITS-1:0]        bound_i,
  output bf8c_pkg::visit_rsp_t         nbr_o,
  output logic                         pass_o
);

  localparam logic [bf8c_pkg::COORD_W-1:0] ROW_LAST = bf8c_pkg::COORD_W'(GRID_ROWS - 1);
  localparam logic [bf8c_pkg::COORD_W-1:0] COL_LAST = bf8c_pkg::COORD_W'(GRID_COLS - 1);

  logic                         row_ok;
  logic                         col_ok;
  logic [bf8c_pkg::COORD_W-1:0] nbr_row;
  logic [bf8c_pkg::COORD_W-1:0] nbr_col;

  // Step the row by the neighbour's offset, drop it at the grid edge
  always_comb begin
    unique case (bf8c_pkg::nbr_dr(nbr_idx_i))
      bf8c_pkg::OFF_MINUS: begin
        nbr_row = center_row_i - 1'b1;
        row_ok  = (center_row_i != '0);
      end
      bf8c_pkg::OFF_PLUS: begin
        nbr_row = center_row_i + 1'b1;
        row_ok  = (center_row_i != ROW_LAST);
      end
      default: begin
        nbr_row = center_row_i;
        row_ok  = 1'b1;
      end
    endcase
  end

  // Same for the column
  always_comb begin
    unique case (bf8c_pkg::nbr_dc(nbr_idx_i))
      bf8c_pkg::OFF_MINUS: begin
        nbr_col = center_col_i - 1'b1;
        col_ok  = (center_col_i != '0);
      end
      bf8c_pkg::OFF_PLUS: begin
        nbr_col = center_col_i + 1'b1;
        col_ok  = (center_col_i != COL_LAST);
      end
      default: begin
        nbr_col = center_col_i;
        col_ok  = 1'b1;
      end
    endcase
  end

  assign nbr_o = '{row: nbr_row, col: nbr_col, on_grid: row_ok && col_ok};

  // A cell is taken if it is neither boundary nor fill colour
  assign pass_o = (pix_i != bound_i) && (pix_i != fill_i);

endmodule

FILE: sv/boundary_fill_8_connected_core.sv
// Flow: write, off-grid and unused-code items go straight to the result; a read waits for the
// registered RAM read; a fill ends early if the seed is refused, else its pace is set by the
// single pixel RAM port pair: one read per neighbour in turn for each recoloured cell.
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset (asynchronous, active low) restores the colour registers and starts a clearing pass
// that zeroes every pixel cell; no word is taken until it ends.
`include "boundary_fill_8_connected_core_defines.svh"

module boundary_fill_8_connected_core #(
  parameter int GRID_ROWS  = bf8c_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS  = bf8c_pkg::GRID_COLS_DEF,
  parameter int COLOR_BITS = bf8c_pkg::COLOR_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // func [1:0], row [7:2], col [13:8], color [21:14], zero [23:22]
  input  logic [bf8c_pkg::TDATA_W-1:0]  s_axis_tdata,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_color [7:0], filled_count [20:8], status [21], zero [23:22]
  output logic [bf8c_pkg::TDATA_W-1:0]  m_axis_tdata,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bf8c_pkg::APB_AW-1:0]   paddr,
  input  logic [bf8c_pkg::APB_DW-1:0]   pwdata,
  output logic [bf8c_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int RW       = $clog2(GRID_ROWS);
  localparam int CW       = $clog2(GRID_COLS);
  localparam int SA       = RW + CW;
  localparam int CELLS    = GRID_ROWS * GRID_COLS;
  localparam int DEPTH_W  = $clog2(CELLS + 1);
  localparam int CW_      = bf8c_pkg::COORD_W;
  localparam int CNT_W    = bf8c_pkg::COUNT_W;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_RDWAIT = 8'b0000_0100,
    ST_SEED   = 8'b0000_1000,
    ST_POP    = 8'b0001_0000,
    ST_LOAD   = 8'b0010_0000,
    ST_SCAN   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  state_e                          state_q, state_d;
  logic [SA-1:0]                   clr_q, clr_d;
  logic [CW_-1:0]                  row_q, row_d;
  logic [CW_-1:0]                  col_q, col_d;
  logic [3:0]                      k_q, k_d;
  logic                            pend_valid_q, pend_valid_d;
  logic [SA-1:0]                   pend_addr_q, pend_addr_d;
  logic [DEPTH_W-1:0]              depth_q, depth_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [bf8c_pkg::COLOR_W-1:0]    res_read_q, res_read_d;
  logic                            res_status_q, res_status_d;
  logic                            out_valid_q, out_valid_d;
  logic [bf8c_pkg::TDATA_W-1:0]    out_data_q, out_data_d;
  logic [bf8c_pkg::COLOR_W-1:0]    fill_q, bound_q;

  // Input word fields
  logic [bf8c_pkg::FUNC_W-1:0]     in_func;
  logic [CW_-1:0]                  in_row;
  logic [CW_-1:0]                  in_col;
  logic [bf8c_pkg::COLOR_W-1:0]    in_color;
  logic                            in_on_grid;
  logic [SA-1:0]                   in_addr;

  // Memory ports
  logic                            pix_we, pix_re;
  logic [SA-1:0]                   pix_waddr, pix_raddr;
  logic [COLOR_BITS-1:0]           pix_wdata, pix_rdata;
  logic                            stk_we, stk_re;
  logic [SA-1:0]                   stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic [COLOR_BITS-1:0]           fc, bc;
  bf8c_pkg::visit_rsp_t            nbr;
  logic                            pass;
  logic [SA-1:0]                   nbr_addr;
  logic                            cfg_wr;

  assign in_func  = s_axis_tdata[1:0];
  assign in_row   = s_axis_tdata[7:2];
  assign in_col   = s_axis_tdata[13:8];
  assign in_color = s_axis_tdata[21:14];
  assign in_on_grid = ({1'b0, in_row} < 7'(GRID_ROWS)) && ({1'b0, in_col} < 7'(GRID_COLS));
  assign in_addr  = {in_row[RW-1:0], in_col[CW-1:0]};
  assign nbr_addr = {nbr.row[RW-1:0], nbr.col[CW-1:0]};

  assign fc = COLOR_BITS'(fill_q);
  assign bc = COLOR_BITS'(bound_q);

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= bf8c_pkg::FILL_RESET;
      bound_q <= bf8c_pkg::BOUND_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bf8c_pkg::REG_FILL:     fill_q  <= pwdata[bf8c_pkg::COLOR_W-1:0];
        bf8c_pkg::REG_BOUNDARY: bound_q <= pwdata[bf8c_pkg::COLOR_W-1:0];
        default:                fill_q  <= fill_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bf8c_pkg::REG_FILL:     prdata = bf8c_pkg::APB_DW'(fill_q);
      bf8c_pkg::REG_BOUNDARY: prdata = bf8c_pkg::APB_DW'(bound_q);
      default:                prdata = '0;
    endcase
  end

  // Memories and the shared visit unit
  bf8c_ram #(
    .DATA_W (COLOR_BITS),
    .ADDR_W (SA)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i (pix_wdata),
    .re_i    (pix_re),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  bf8c_ram #(
    .DATA_W (SA),
    .ADDR_W (SA)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  bf8c_visit #(
    .GRID_ROWS  (GRID_ROWS),
    .GRID_COLS  (GRID_COLS),
    .COLOR_BITS (COLOR_BITS)
  ) u_visit (
    .center_row_i (row_q),
    .center_col_i (col_q),
    .nbr_idx_i    (k_q[2:0]),
    .pix_i        (pix_rdata),
    .fill_i       (fc),
    .bound_i      (bc),
    .nbr_o        (nbr),
    .pass_o       (pass)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    row_d        = row_q;
    col_d        = col_q;
    k_d          = k_q;
    pend_valid_d = pend_valid_q;
    pend_addr_d  = pend_addr_q;
    depth_d      = depth_q;
    count_d      = count_q;
    res_read_d   = res_read_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    pix_we       = 1'b0;
    pix_waddr    = pend_addr_q;
    pix_wdata    = fc;
    pix_re       = 1'b0;
    pix_raddr    = nbr_addr;
    stk_we       = 1'b0;
    stk_waddr    = SA'(depth_q);
    stk_wdata    = pend_addr_q;
    stk_re       = 1'b0;
    stk_raddr    = SA'(depth_q - 1'b1);

    // Drop the result word once taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        pix_we    = 1'b1;
        pix_waddr = clr_q;
        pix_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          res_read_d   = '0;
          res_status_d = 1'b0;
          count_d      = '0;
          depth_d      = '0;
          row_d        = in_row;
          col_d        = in_col;
          priority if (in_func != bf8c_pkg::FUNC_WRITE && in_func != bf8c_pkg::FUNC_READ
                       && in_func != bf8c_pkg::FUNC_FILL) begin
            state_d = ST_DONE;
          end else if (!in_on_grid) begin
            res_status_d = 1'b1;
            state_d      = ST_DONE;
          end else if (in_func == bf8c_pkg::FUNC_WRITE) begin
            pix_we    = 1'b1;
            pix_waddr = in_addr;
            pix_wdata = COLOR_BITS'(in_color);
            state_d   = ST_DONE;
          end else if (in_func == bf8c_pkg::FUNC_READ) begin
            pix_re    = 1'b1;
            pix_raddr = in_addr;
            state_d   = ST_RDWAIT;
          end else begin
            pix_re    = 1'b1;
            pix_raddr = in_addr;
            state_d   = ST_SEED;
          end
        end
      end
      ST_RDWAIT: begin
        res_read_d = bf8c_pkg::COLOR_W'(pix_rdata);
        state_d    = ST_DONE;
      end
      ST_SEED: begin
        // Take the seed if it may be filled, else finish with nothing done
        if (pass) begin
          pix_we    = 1'b1;
          pix_waddr = {row_q[RW-1:0], col_q[CW-1:0]};
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = {row_q[RW-1:0], col_q[CW-1:0]};
          depth_d   = DEPTH_W'(1);
          count_d   = CNT_W'(1);
          state_d   = ST_POP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_POP: begin
        if (depth_q == '0) begin
          state_d = ST_DONE;
        end else begin
          stk_re  = 1'b1;
          depth_d = depth_q - 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        row_d        = CW_'(stk_rdata[SA-1:CW]);
        col_d        = CW_'(stk_rdata[CW-1:0]);
        k_d          = '0;
        pend_valid_d = 1'b0;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        // Recolour and push the neighbour read last cycle
        if (pend_valid_q && pass) begin
          pix_we  = 1'b1;
          stk_we  = 1'b1;
          depth_d = depth_q + 1'b1;
          count_d = count_q + 1'b1;
        end
        // Issue the read of the next neighbour
        if (k_q == bf8c_pkg::NBR_COUNT) begin
          pend_valid_d = 1'b0;
          state_d      = ST_POP;
        end else begin
          pix_re       = nbr.on_grid;
          pend_valid_d = nbr.on_grid;
          pend_addr_d  = nbr_addr;
          k_d          = k_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {2'b00, res_status_q, count_q, res_read_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      k_q          <= '0;
      pend_valid_q <= 1'b0;
      depth_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      k_q          <= k_d;
      pend_valid_q <= pend_valid_d;
      depth_q      <= depth_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    row_q        <= row_d;
    col_q        <= col_d;
    pend_addr_q  <= pend_addr_d;
    count_q      <= count_d;
    res_read_q   <= res_read_d;
    res_status_q <= res_status_d;
    out_data_q   <= out_data_d;
  end

  // Checks
  `BF8C_ASSERT_IMP(a_push_recolours, stk_we, pix_we && (pix_waddr == stk_wdata),
                   "push without recolouring the same cell")
  `BF8C_ASSERT_NXT(a_empty_stack_ends, (state_q == ST_POP) && (depth_q == '0),
                   state_q == ST_DONE, "empty stack did not end the fill")
  `BF8C_ASSERT_IMP(a_count_covers_depth,
                   (state_q == ST_POP) || (state_q == ST_LOAD) || (state_q == ST_SCAN),
                   CNT_W'(depth_q) <= count_q, "stack deeper than cells recoloured")
  `BF8C_ASSERT_IMP(a_no_word_in_clear, state_q == ST_CLEAR, !s_axis_tready,
                   "input word taken during clearing pass")

endmodule
